### hw/rtl/pn3_pkg.sv
package pn3_pkg;

  localparam int PERM_SIZE    = 256;
  localparam int FADE_ENTRIES = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 24;
  localparam int CELL_W       = 8;
  localparam int FADE_W       = 16;
  localparam int FIDX_W       = $clog2(FADE_ENTRIES);
  localparam int OUT_W        = 17;
  localparam int OUT_MAX      = 65535;
  localparam int OUT_MIN      = -65536;
  localparam int IQ_DEPTH     = 4;
  localparam int OQ_DEPTH     = 4;

  // corner offset, gradient dot and lerp widths
  // a dot of two -1.0 offsets, both negated, reaches +2.0 exactly
  localparam int CW = FRAC_BITS + 1;
  localparam int GW = FRAC_BITS + 3;

  typedef logic [FADE_W-1:0] fade_tbl_t [FADE_ENTRIES];

  typedef struct packed {
    logic [CELL_W-1:0]    cell_x;
    logic [CELL_W-1:0]    cell_y;
    logic [CELL_W-1:0]    cell_z;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
    logic [FRAC_BITS-1:0] frac_z;
    logic [FIDX_W-1:0]    fidx_x;
    logic [FIDX_W-1:0]    fidx_y;
    logic [FIDX_W-1:0]    fidx_z;
  } cls_t;

  typedef struct packed {
    logic vld;
    logic full;
  } qstat_t;

  localparam logic [7:0] PERM [PERM_SIZE] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // fade(i/d) = 6t^5 - 15t^4 + 10t^3 in Q0.16, round half up, evaluated at elaboration
  localparam longint unsigned FADE_D  = longint'(FADE_ENTRIES - 1);
  localparam longint unsigned FADE_D5 = FADE_D * FADE_D * FADE_D * FADE_D * FADE_D;

  function automatic fade_tbl_t gen_fade();
    fade_tbl_t       t;
    longint unsigned i;
    longint unsigned poly;
    longint unsigned num;
    longint unsigned q;
    longint unsigned rem;
    for (int n = 0; n < FADE_ENTRIES; n++) begin
      i    = longint'(n);
      poly = 6 * i * i + 10 * FADE_D * FADE_D - 15 * i * FADE_D;
      num  = i * i * i * poly;
      q    = num / FADE_D5;
      rem  = num % FADE_D5;
      for (int k = 0; k < 16; k++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= FADE_D5) begin
          rem = rem - FADE_D5;
          q   = q | 64'd1;
        end
      end
      if (rem >= FADE_D5 - rem) begin
        q = q + 1;
      end
      t[n] = (q > 65535) ? 16'hFFFF : q[15:0];
    end
    return t;
  endfunction

endpackage

### hw/rtl/pn3_queue.sv
module pn3_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### hw/rtl/pn3_front.sv
module pn3_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [pn3_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [pn3_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [pn3_pkg::COORD_W-1:0]   in_coord_z,
  input  logic                          q_full,
  output logic                          q_push,
  output pn3_pkg::cls_t                 q_item
);

  localparam int FB = pn3_pkg::FRAC_BITS;
  localparam int IW = pn3_pkg::FIDX_W;
  localparam int PRW = FB + IW;

  logic          vld_r, vld_nxt;
  pn3_pkg::cls_t item_r, item_nxt;
  logic          accept;

  function automatic logic [IW-1:0] fade_idx(input logic [FB-1:0] f);
    logic [PRW-1:0] p;
    p = {IW'(0), f} * PRW'(pn3_pkg::FADE_ENTRIES - 1);
    return p[PRW-1:FB];
  endfunction

  assign q_push  = vld_r && !q_full;
  assign in_full = vld_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_item  = item_r;

  always_comb begin
    item_nxt.cell_x = pn3_pkg::CELL_W'(in_coord_x >> FB);
    item_nxt.cell_y = pn3_pkg::CELL_W'(in_coord_y >> FB);
    item_nxt.cell_z = pn3_pkg::CELL_W'(in_coord_z >> FB);
    item_nxt.frac_x = in_coord_x[FB-1:0];
    item_nxt.frac_y = in_coord_y[FB-1:0];
    item_nxt.frac_z = in_coord_z[FB-1:0];
    item_nxt.fidx_x = fade_idx(in_coord_x[FB-1:0]);
    item_nxt.fidx_y = fade_idx(in_coord_y[FB-1:0]);
    item_nxt.fidx_z = fade_idx(in_coord_z[FB-1:0]);
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

### hw/rtl/pn3_back.sv
module pn3_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pn3_pkg::qstat_t             iq,
  input  pn3_pkg::cls_t               iq_item,
  output logic                        iq_pop,
  input  logic                        oq_full,
  output logic                        oq_push,
  output logic [pn3_pkg::OUT_W-1:0]   oq_data
);

  localparam int FB   = pn3_pkg::FRAC_BITS;
  localparam int CW   = pn3_pkg::CW;
  localparam int GW   = pn3_pkg::GW;
  localparam int FW   = pn3_pkg::FADE_W;
  localparam int DW   = GW + 1;
  localparam int MW   = FW + 1 + DW;
  localparam int NST  = 12;
  localparam int SHR  = (FB >= 15) ? FB - 15 : 0;
  localparam int SHL  = (FB < 15) ? 15 - FB : 0;
  localparam int SC_W = GW + SHL;

  localparam pn3_pkg::fade_tbl_t FADE_TBL = pn3_pkg::gen_fade();

  logic [NST-1:0] vld_r;
  logic           en;

  // stage payloads
  logic [7:0]           pa_r, pb_r, y0_r, z0_r, z1_r;
  logic [7:0]           a_r, b_r;
  logic [7:0]           aa_r, ab_r, ba_r, bb_r;
  logic [3:0]           h_r [8];
  logic [FB-1:0]        fx_r [4];
  logic [FB-1:0]        fy_r [4];
  logic [FB-1:0]        fz_r [4];
  logic [FW-1:0]        u_r [5];
  logic [FW-1:0]        v_r [7];
  logic [FW-1:0]        w_r [9];
  logic signed [GW-1:0] g_r [8];
  logic signed [MW-1:0] px_r [4];
  logic signed [GW-1:0] ax_r [4];
  logic signed [GW-1:0] lx_r [4];
  logic signed [MW-1:0] py_r [2];
  logic signed [GW-1:0] ay_r [2];
  logic signed [GW-1:0] ly_r [2];
  logic signed [MW-1:0] pz_r;
  logic signed [GW-1:0] az_r;
  logic signed [GW-1:0] lz_r;
  logic [pn3_pkg::OUT_W-1:0] res_r;

  logic signed [CW-1:0] cx0, cy0, cz0, cx1, cy1, cz1;
  logic signed [SC_W-1:0] rs, rsc;

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [CW-1:0] x,
                                                input logic signed [CW-1:0] y,
                                                input logic signed [CW-1:0] z);
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    gu = (h < 4'd8) ? GW'(x) : GW'(y);
    if (h < 4'd4) begin
      gv = GW'(y);
    end else if (h inside {4'd12, 4'd14}) begin
      gv = GW'(x);
    end else begin
      gv = GW'(z);
    end
    if (h[0]) begin
      gu = -gu;
    end
    if (h[1]) begin
      gv = -gv;
    end
    return gu + gv;
  endfunction

  function automatic logic signed [MW-1:0] lmul(input logic [FW-1:0] w,
                                                input logic signed [GW-1:0] a,
                                                input logic signed [GW-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(b) - DW'(a);
    return MW'($signed({1'b0, w}) * d);
  endfunction

  function automatic logic signed [GW-1:0] ladd(input logic signed [GW-1:0] a,
                                                input logic signed [MW-1:0] p);
    return GW'(MW'(a) + (p >>> FW));
  endfunction

  assign en      = !oq_full;
  assign iq_pop  = en && iq.vld;
  assign oq_push = en && vld_r[NST-1];
  assign oq_data = res_r;

  always_comb begin
    cx0 = CW'(fx_r[3]);
    cy0 = CW'(fy_r[3]);
    cz0 = CW'(fz_r[3]);
    cx1 = cx0 - (CW'(1) <<< FB);
    cy1 = cy0 - (CW'(1) <<< FB);
    cz1 = cz0 - (CW'(1) <<< FB);
    rs  = SC_W'(lz_r);
    rsc = (FB >= 15) ? (rs >>> SHR) : (rs <<< SHL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], iq.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // first hash level and fade weights
      pa_r    <= pn3_pkg::PERM[iq_item.cell_x];
      pb_r    <= pn3_pkg::PERM[iq_item.cell_x + 8'd1];
      y0_r    <= iq_item.cell_y;
      z0_r    <= iq_item.cell_z;
      fx_r[0] <= iq_item.frac_x;
      fy_r[0] <= iq_item.frac_y;
      fz_r[0] <= iq_item.frac_z;
      u_r[0]  <= FADE_TBL[iq_item.fidx_x];
      v_r[0]  <= FADE_TBL[iq_item.fidx_y];
      w_r[0]  <= FADE_TBL[iq_item.fidx_z];
      for (int i = 1; i < 4; i++) begin
        fx_r[i] <= fx_r[i-1];
        fy_r[i] <= fy_r[i-1];
        fz_r[i] <= fz_r[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        u_r[i] <= u_r[i-1];
      end
      for (int i = 1; i < 7; i++) begin
        v_r[i] <= v_r[i-1];
      end
      for (int i = 1; i < 9; i++) begin
        w_r[i] <= w_r[i-1];
      end
      a_r  <= pa_r + y0_r;
      b_r  <= pb_r + y0_r;
      z1_r <= z0_r;
      aa_r <= pn3_pkg::PERM[a_r] + z1_r;
      ab_r <= pn3_pkg::PERM[a_r + 8'd1] + z1_r;
      ba_r <= pn3_pkg::PERM[b_r] + z1_r;
      bb_r <= pn3_pkg::PERM[b_r + 8'd1] + z1_r;
      // corner hashes, front face then back face
      h_r[0] <= pn3_pkg::PERM[aa_r][3:0];
      h_r[1] <= pn3_pkg::PERM[ba_r][3:0];
      h_r[2] <= pn3_pkg::PERM[ab_r][3:0];
      h_r[3] <= pn3_pkg::PERM[bb_r][3:0];
      h_r[4] <= pn3_pkg::PERM[aa_r + 8'd1][3:0];
      h_r[5] <= pn3_pkg::PERM[ba_r + 8'd1][3:0];
      h_r[6] <= pn3_pkg::PERM[ab_r + 8'd1][3:0];
      h_r[7] <= pn3_pkg::PERM[bb_r + 8'd1][3:0];
      g_r[0] <= grad(h_r[0], cx0, cy0, cz0);
      g_r[1] <= grad(h_r[1], cx1, cy0, cz0);
      g_r[2] <= grad(h_r[2], cx0, cy1, cz0);
      g_r[3] <= grad(h_r[3], cx1, cy1, cz0);
      g_r[4] <= grad(h_r[4], cx0, cy0, cz1);
      g_r[5] <= grad(h_r[5], cx1, cy0, cz1);
      g_r[6] <= grad(h_r[6], cx0, cy1, cz1);
      g_r[7] <= grad(h_r[7], cx1, cy1, cz1);
      for (int i = 0; i < 4; i++) begin
        px_r[i] <= lmul(u_r[4], g_r[2*i], g_r[2*i+1]);
        ax_r[i] <= g_r[2*i];
        lx_r[i] <= ladd(ax_r[i], px_r[i]);
      end
      for (int i = 0; i < 2; i++) begin
        py_r[i] <= lmul(v_r[6], lx_r[2*i], lx_r[2*i+1]);
        ay_r[i] <= lx_r[2*i];
        ly_r[i] <= ladd(ay_r[i], py_r[i]);
      end
      pz_r <= lmul(w_r[8], ly_r[0], ly_r[1]);
      az_r <= ly_r[0];
      lz_r <= ladd(az_r, pz_r);
      // to q2.15, clamp
      if (rsc > SC_W'(pn3_pkg::OUT_MAX)) begin
        res_r <= pn3_pkg::OUT_W'(pn3_pkg::OUT_MAX);
      end else if (rsc < SC_W'(pn3_pkg::OUT_MIN)) begin
        res_r <= pn3_pkg::OUT_W'(pn3_pkg::OUT_MIN);
      end else begin
        res_r <= rsc[pn3_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

### hw/rtl/perlin_noise_3d_top.sv
// 3d gradient noise, one point per transaction.
// input queue: drive in_coord_x/y/z (cell in bits 23..16, fraction below) with in_push;
// the transaction is taken on a clock edge with in_push high and in_full low.
// result queue: out_noise_value (signed q2.15) is valid while out_empty is low and is
// taken on an edge with out_pop high.
// throughput: one point per cycle while the result queue has room, set by the fully
// pipelined back end (three hash levels, gradients, seven lerps split into multiply
// and add stages). a point passes the front register, the input queue, the 12 back
// stages and the result queue between the accepting edge and out_empty going low.
// the front register and input queue keep taking points while the back end is stalled;
// with out_pop low the back end halts once the result queue fills, and in_full rises
// only after the input queue and the front register are full.
// reset: synchronous rst_n low empties both queues and the pipeline; in_full is low
// and out_empty high after it. permutation and fade tables are constant.
module perlin_noise_3d_top #(
  parameter int IQ_DEPTH = pn3_pkg::IQ_DEPTH,
  parameter int OQ_DEPTH = pn3_pkg::OQ_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [pn3_pkg::COORD_W-1:0]       in_coord_x,
  input  logic [pn3_pkg::COORD_W-1:0]       in_coord_y,
  input  logic [pn3_pkg::COORD_W-1:0]       in_coord_z,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [pn3_pkg::OUT_W-1:0]  out_noise_value
);

  localparam int CLS_W = $bits(pn3_pkg::cls_t);

  logic                       fq_full;
  logic                       fq_push;
  pn3_pkg::cls_t              fq_item;
  logic [CLS_W-1:0]           iq_dout;
  logic                       iq_empty;
  pn3_pkg::qstat_t            iq;
  logic                       iq_pop;
  logic                       oq_full;
  logic                       oq_push;
  logic [pn3_pkg::OUT_W-1:0]  oq_data;
  logic [pn3_pkg::OUT_W-1:0]  oq_dout;

  pn3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .q_full     (fq_full),
    .q_push     (fq_push),
    .q_item     (fq_item)
  );

  pn3_queue #(.W(CLS_W), .DEPTH(IQ_DEPTH)) u_iq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_item),
    .full  (fq_full),
    .pop   (iq_pop),
    .dout  (iq_dout),
    .empty (iq_empty)
  );

  assign iq.vld  = !iq_empty;
  assign iq.full = fq_full;

  pn3_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .iq      (iq),
    .iq_item (pn3_pkg::cls_t'(iq_dout)),
    .iq_pop  (iq_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_data)
  );

  pn3_queue #(.W(pn3_pkg::OUT_W), .DEPTH(OQ_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_data),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  (oq_dout),
    .empty (out_empty)
  );

  assign out_noise_value = $signed(oq_dout);

endmodule

### hw/rtl/pn3_checker.sv
module pn3_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic signed [pn3_pkg::OUT_W-1:0]  out_noise_value
);

  // reset leaves no result behind
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_rst_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // a waiting result is neither dropped nor changed
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("waiting result lost");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_noise_value))
    else $error("waiting result changed");

endmodule

bind perlin_noise_3d_top pn3_checker u_pn3_checker (.*);
